/* rtl/pop_pkg.sv */
// Package for the Pauli operator product block.
// Holds the field widths, the fixed-point constants, the quarter-turn codes and
// the stage payload structs. Depends on nothing.
package pop_pkg;

    // Field widths
    localparam int MASK_W         = 64;
    localparam int COEF_W         = 32;
    localparam int FRAC_BITS      = 24;
    localparam int PROD_W         = 2 * COEF_W;
    localparam int SUM_W          = PROD_W + 1;
    localparam int MAG_W          = PROD_W;
    localparam int RND_W          = MAG_W - FRAC_BITS + 1;
    localparam int TREE_LEVELS    = $clog2(MASK_W);
    localparam int QUBITS_DEFAULT = 64;

    // Rounding and clipping constants: the rounding half in product LSB units, the limits in output LSB units
    localparam logic [MAG_W:0]   ROUND_HALF = (MAG_W + 1)'(1) << (FRAC_BITS - 1);
    localparam logic [RND_W-1:0] POS_LIMIT  = (RND_W'(1) << (COEF_W - 1)) - RND_W'(1);
    localparam logic [RND_W-1:0] NEG_LIMIT  = RND_W'(1) << (COEF_W - 1);

    // Phase exponent k: extra factor i to the k
    typedef enum logic [1:0] {
        TURN_0 = 2'd0,
        TURN_1 = 2'd1,
        TURN_2 = 2'd2,
        TURN_3 = 2'd3
    } turn_t;

    // Registered operand request
    typedef struct packed {
        logic [MASK_W-1:0]        lf;
        logic [MASK_W-1:0]        lp;
        logic [MASK_W-1:0]        rf;
        logic [MASK_W-1:0]        rp;
        logic signed [COEF_W-1:0] lre;
        logic signed [COEF_W-1:0] lim;
        logic signed [COEF_W-1:0] rre;
        logic signed [COEF_W-1:0] rim;
    } op_t;

    // After the multiplier stage
    typedef struct packed {
        logic [MASK_W-1:0]        flip;
        logic [MASK_W-1:0]        phase;
        turn_t                    k;
        logic signed [PROD_W-1:0] rr;
        logic signed [PROD_W-1:0] ii;
        logic signed [PROD_W-1:0] ri;
        logic signed [PROD_W-1:0] ir;
    } mult_t;

    // After the complex sum
    typedef struct packed {
        logic [MASK_W-1:0]       flip;
        logic [MASK_W-1:0]       phase;
        turn_t                   k;
        logic signed [SUM_W-1:0] re;
        logic signed [SUM_W-1:0] im;
    } sum_t;

    // Sign and magnitude after the i^k rotation
    typedef struct packed {
        logic [MASK_W-1:0] flip;
        logic [MASK_W-1:0] phase;
        turn_t             k;
        logic              nre;
        logic [MAG_W-1:0]  mre;
        logic              nim;
        logic [MAG_W-1:0]  mim;
    } mag_t;

    // Final result
    typedef struct packed {
        logic [MASK_W-1:0]        flip;
        logic [MASK_W-1:0]        phase;
        logic signed [COEF_W-1:0] re;
        logic signed [COEF_W-1:0] im;
        turn_t                    k;
        logic                     sat;
    } res_t;

endpackage

/* rtl/pop_mult.sv */
// Multiplier stage: four coefficient partial products, phase exponent and mask XOR.
// Uses pop_pkg for the operand and product structs.
module pop_mult
    import pop_pkg::*;
(
    input  logic  clk,
    input  logic  load,
    input  op_t   op,
    output mult_t mult
);

    mult_t mult_reg;
    mult_t mult_next;

    logic [MASK_W-1:0] xl, yl, zl;
    logic [MASK_W-1:0] xr, yr, zr;
    logic [MASK_W-1:0] pos_bits;
    logic [MASK_W-1:0] neg_bits;

    // Sum per-qubit contributions (+1, -1 or 0) modulo 4 through a balanced tree
    function automatic logic [1:0] phase_sum(input logic [MASK_W-1:0] pos,
                                             input logic [MASK_W-1:0] neg);
        logic [1:0] acc [MASK_W];
        for (int i = 0; i < MASK_W; i++) begin
            acc[i] = {neg[i], pos[i] | neg[i]};
        end
        for (int lvl = 0; lvl < TREE_LEVELS; lvl++) begin
            for (int i = 0; i < ((MASK_W / 2) >> lvl); i++) begin
                acc[i] = acc[2 * i] + acc[2 * i + 1];
            end
        end
        return acc[0];
    endfunction

    // Decode letters per qubit and find the ordered pairs
    always_comb
    begin
        xl = op.lf & ~op.lp;
        yl = op.lf & op.lp;
        zl = op.lp & ~op.lf;
        xr = op.rf & ~op.rp;
        yr = op.rf & op.rp;
        zr = op.rp & ~op.rf;
        pos_bits = (xl & yr) | (yl & zr) | (zl & xr);
        neg_bits = (xl & zr) | (yl & xr) | (zl & yr);
    end

    // Build the next stage contents
    always_comb
    begin
        mult_next.flip  = op.lf ^ op.rf;
        mult_next.phase = op.lp ^ op.rp;
        mult_next.k     = turn_t'(phase_sum(pos_bits, neg_bits));
        mult_next.rr    = op.lre * op.rre;
        mult_next.ii    = op.lim * op.rim;
        mult_next.ri    = op.lre * op.rim;
        mult_next.ir    = op.lim * op.rre;
    end

    // Hold products until the next stage takes them
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            mult_reg <= mult_next;
        end
    end

    assign mult = mult_reg;

endmodule

/* rtl/pop_combine.sv */
// Complex sum and sign-magnitude rotation stages of the coefficient path.
// Uses pop_pkg for the stage structs and quarter-turn codes.
module pop_combine
    import pop_pkg::*;
(
    input  logic  clk,
    input  logic  load_sum,
    input  logic  load_mag,
    input  mult_t mult,
    output mag_t  mag
);

    sum_t sum_reg;
    sum_t sum_next;
    mag_t mag_reg;
    mag_t mag_next;

    logic signed [SUM_W-1:0] neg_re;
    logic signed [SUM_W-1:0] neg_im;
    logic                    sre, sim;
    logic [MAG_W-1:0]        are, aim;

    // Form the exact real and imaginary parts
    always_comb
    begin
        sum_next.flip  = mult.flip;
        sum_next.phase = mult.phase;
        sum_next.k     = mult.k;
        sum_next.re    = SUM_W'(mult.rr) - SUM_W'(mult.ii);
        sum_next.im    = SUM_W'(mult.ri) + SUM_W'(mult.ir);
    end

    always_ff @(posedge clk)
    begin
        if (load_sum)
        begin
            sum_reg <= sum_next;
        end
    end

    // Take sign and magnitude, then rotate by i^k
    always_comb
    begin
        neg_re = -sum_reg.re;
        neg_im = -sum_reg.im;
        sre    = sum_reg.re[SUM_W-1];
        sim    = sum_reg.im[SUM_W-1];
        are    = sre ? neg_re[MAG_W-1:0] : sum_reg.re[MAG_W-1:0];
        aim    = sim ? neg_im[MAG_W-1:0] : sum_reg.im[MAG_W-1:0];

        mag_next.flip  = sum_reg.flip;
        mag_next.phase = sum_reg.phase;
        mag_next.k     = sum_reg.k;
        unique case (sum_reg.k)
            TURN_1:
            begin
                mag_next.nre = !sim;
                mag_next.mre = aim;
                mag_next.nim = sre;
                mag_next.mim = are;
            end
            TURN_2:
            begin
                mag_next.nre = !sre;
                mag_next.mre = are;
                mag_next.nim = !sim;
                mag_next.mim = aim;
            end
            TURN_3:
            begin
                mag_next.nre = sim;
                mag_next.mre = aim;
                mag_next.nim = !sre;
                mag_next.mim = are;
            end
            default:
            begin
                mag_next.nre = sre;
                mag_next.mre = are;
                mag_next.nim = sim;
                mag_next.mim = aim;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (load_mag)
        begin
            mag_reg <= mag_next;
        end
    end

    assign mag = mag_reg;

endmodule

/* rtl/pop_round.sv */
// Output stage: round to 24 fraction bits, clip to 32 bits, flag clipping.
// Uses pop_pkg for the magnitude and result structs and rounding constants.
module pop_round
    import pop_pkg::*;
(
    input  logic clk,
    input  logic load,
    input  mag_t mag,
    output res_t res
);

    res_t             res_reg;
    res_t             res_next;
    logic [COEF_W:0]  re_pack;
    logic [COEF_W:0]  im_pack;

    // Round half away from zero on the magnitude, clip, restore sign; MSB is the clip flag
    function automatic logic [COEF_W:0] round_sat(input logic             neg,
                                                  input logic [MAG_W-1:0] m);
        logic [MAG_W:0]   biased;
        logic [RND_W-1:0] q;
        logic [RND_W-1:0] clipped;
        logic [RND_W-1:0] negated;
        logic             sat;
        biased = {1'b0, m} + ROUND_HALF;
        q      = biased[MAG_W:FRAC_BITS];
        if (neg)
        begin
            sat     = (q > NEG_LIMIT);
            clipped = sat ? NEG_LIMIT : q;
        end
        else
        begin
            sat     = (q > POS_LIMIT);
            clipped = sat ? POS_LIMIT : q;
        end
        negated = -clipped;
        return {sat, neg ? negated[COEF_W-1:0] : clipped[COEF_W-1:0]};
    endfunction

    always_comb
    begin
        re_pack        = round_sat(mag.nre, mag.mre);
        im_pack        = round_sat(mag.nim, mag.mim);
        res_next.flip  = mag.flip;
        res_next.phase = mag.phase;
        res_next.re    = $signed(re_pack[COEF_W-1:0]);
        res_next.im    = $signed(im_pack[COEF_W-1:0]);
        res_next.k     = mag.k;
        res_next.sat   = re_pack[COEF_W] | im_pack[COEF_W];
    end

    // Hold the result until the consumer takes it
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

/* rtl/pauli_operator_product.sv */
// Pauli operator product: multiplies two Pauli strings in symplectic form
// (bit-flip mask, phase-flip mask, complex Q8.24 coefficient). The result masks
// are the XOR of the operand masks, quarter_turns is the phase exponent k, and
// the coefficient is left * right * i^k rounded half away from zero and clipped
// to 32 bits, with coef_saturated set on clipping. Mask bits at or above QUBITS
// are ignored and read back as zero. One request is taken every cycle while
// op_stall is low; after the input register each result passes four more
// registers (multiplier, complex sum, rotation, rounding) on its way to the
// product port. The stages are elastic, so a stall on the result side fills
// bubbles before it holds off new requests.
// Depends on pop_pkg, pop_mult, pop_combine and pop_round.
module pauli_operator_product
    import pop_pkg::*;
#(
    parameter int QUBITS = QUBITS_DEFAULT
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     op_valid,
    output logic                     op_stall,
    input  logic [MASK_W-1:0]        left_flip_mask,
    input  logic [MASK_W-1:0]        left_phase_mask,
    input  logic signed [COEF_W-1:0] left_coef_re,
    input  logic signed [COEF_W-1:0] left_coef_im,
    input  logic [MASK_W-1:0]        right_flip_mask,
    input  logic [MASK_W-1:0]        right_phase_mask,
    input  logic signed [COEF_W-1:0] right_coef_re,
    input  logic signed [COEF_W-1:0] right_coef_im,
    output logic                     prod_valid,
    input  logic                     prod_stall,
    output logic [MASK_W-1:0]        prod_flip_mask,
    output logic [MASK_W-1:0]        prod_phase_mask,
    output logic signed [COEF_W-1:0] prod_coef_re,
    output logic signed [COEF_W-1:0] prod_coef_im,
    output logic [1:0]               quarter_turns,
    output logic                     coef_saturated
);

    localparam int STAGES = 5;
    localparam logic [MASK_W-1:0] QUBIT_MASK = {MASK_W{1'b1}} >> (MASK_W - QUBITS);

    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] valid_next;
    logic [STAGES-1:0] ready;
    logic [STAGES-1:0] upstream;
    logic [STAGES-1:0] load;

    op_t   op_reg;
    op_t   op_next;
    mult_t mult;
    mag_t  mag;
    res_t  res;

    // Ready ripples back from the output; a stage is free when empty or draining
    always_comb
    begin
        ready[STAGES-1] = !valid_reg[STAGES-1] || !prod_stall;
        for (int s = STAGES - 2; s >= 0; s--)
        begin
            ready[s] = !valid_reg[s] || ready[s+1];
        end
        upstream = {valid_reg[STAGES-2:0], op_valid};
        load     = ready & upstream;
        for (int s = 0; s < STAGES; s++)
        begin
            valid_next[s] = ready[s] ? upstream[s] : valid_reg[s];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Capture the request, dropping mask bits beyond the qubit count
    always_comb
    begin
        op_next.lf  = left_flip_mask & QUBIT_MASK;
        op_next.lp  = left_phase_mask & QUBIT_MASK;
        op_next.rf  = right_flip_mask & QUBIT_MASK;
        op_next.rp  = right_phase_mask & QUBIT_MASK;
        op_next.lre = left_coef_re;
        op_next.lim = left_coef_im;
        op_next.rre = right_coef_re;
        op_next.rim = right_coef_im;
    end

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            op_reg <= op_next;
        end
    end

    pop_mult u_mult (
        .clk  (clk),
        .load (load[1]),
        .op   (op_reg),
        .mult (mult)
    );

    pop_combine u_combine (
        .clk      (clk),
        .load_sum (load[2]),
        .load_mag (load[3]),
        .mult     (mult),
        .mag      (mag)
    );

    pop_round u_round (
        .clk  (clk),
        .load (load[4]),
        .mag  (mag),
        .res  (res)
    );

    // Drive the ports
    assign op_stall        = !ready[0];
    assign prod_valid      = valid_reg[STAGES-1];
    assign prod_flip_mask  = res.flip;
    assign prod_phase_mask = res.phase;
    assign prod_coef_re    = res.re;
    assign prod_coef_im    = res.im;
    assign quarter_turns   = res.k;
    assign coef_saturated  = res.sat;

    // A taken request always lands in the input register
    a_request_captured: assert property (@(posedge clk) disable iff (!rst_n)
        (op_valid && !op_stall) |=> valid_reg[0])
        else $error("accepted request not held in the input register");

    // With every stage full and the output stalled, requests are held off
    a_full_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        ((&valid_reg) && prod_stall) |-> op_stall)
        else $error("request taken while the pipeline is full and stalled");

    // Result masks carry nothing above the qubit count
    a_mask_range: assert property (@(posedge clk) disable iff (!rst_n)
        prod_valid |-> (((prod_flip_mask | prod_phase_mask) & ~QUBIT_MASK) == '0))
        else $error("mask bits set beyond the qubit count");

    // The clip flag only appears with a coefficient part at a bound
    a_sat_at_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (prod_valid && coef_saturated) |->
            (prod_coef_re == 32'sh7fffffff || prod_coef_re == 32'sh80000000 ||
             prod_coef_im == 32'sh7fffffff || prod_coef_im == 32'sh80000000))
        else $error("clip flag set with no coefficient part at a bound");

endmodule

/* tb/pauli_operator_product_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for pauli_operator_product: directed operand pairs, then random ones
// under changing sender and receiver idling, each product checked against a hand-written value or a local predictor.
// Depends on pop_pkg and the pauli_operator_product RTL.
module pauli_operator_product_tb
    import pop_pkg::*;
();

    localparam int EXACT_W       = 2 * COEF_W + 4;
    localparam int STUCK_LIMIT   = 4000;
    localparam int DRAIN_CYCLES  = 20;
    localparam int PHASE1_ITEMS  = 300;
    localparam int PHASE2_ITEMS  = 315;
    localparam int PHASE3_ITEMS  = 315;

    localparam logic [MASK_W-1:0] QUBIT_MASK = {MASK_W{1'b1}} >> (MASK_W - QUBITS_DEFAULT);
    localparam logic [MASK_W-1:0] MASK_ALL   = {MASK_W{1'b1}};
    localparam logic [MASK_W-1:0] MASK_ENDS  = 64'h8000_0000_0000_0001;
    localparam logic [MASK_W-1:0] MASK_TOP   = 64'h8000_0000_0000_0000;

    localparam logic signed [COEF_W-1:0] ONE       = 32'sh0100_0000;
    localparam logic signed [COEF_W-1:0] MINUS_ONE = 32'shFF00_0000;
    localparam logic signed [COEF_W-1:0] MOST_POS  = 32'sh7FFF_FFFF;
    localparam logic signed [COEF_W-1:0] MOST_NEG  = 32'sh8000_0000;
    localparam logic signed [COEF_W-1:0] HALF      = 32'sh0080_0000;
    localparam logic signed [COEF_W-1:0] LSB       = 32'sh0000_0001;
    localparam logic signed [COEF_W-1:0] MINUS_LSB = 32'shFFFF_FFFF;

    localparam logic [EXACT_W-1:0] HALF_UNIT = EXACT_W'(1) << (FRAC_BITS - 1);
    localparam logic [EXACT_W-1:0] POS_BOUND = EXACT_W'(32'h7FFF_FFFF);
    localparam logic [EXACT_W-1:0] NEG_BOUND = EXACT_W'(32'h8000_0000);

    typedef struct packed {
        logic [MASK_W-1:0]        left_flip;
        logic [MASK_W-1:0]        left_phase;
        logic signed [COEF_W-1:0] left_re;
        logic signed [COEF_W-1:0] left_im;
        logic [MASK_W-1:0]        right_flip;
        logic [MASK_W-1:0]        right_phase;
        logic signed [COEF_W-1:0] right_re;
        logic signed [COEF_W-1:0] right_im;
    } operand_pair_t;

    typedef struct packed {
        logic [MASK_W-1:0]        flip;
        logic [MASK_W-1:0]        phase;
        logic signed [COEF_W-1:0] re;
        logic signed [COEF_W-1:0] im;
        turn_t                    turns;
        logic                     clipped;
    } pauli_product_t;

    typedef struct {
        operand_pair_t  pair;
        logic           typed;
        pauli_product_t want;
    } directed_row_t;

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     op_valid;
    logic                     op_stall;
    logic [MASK_W-1:0]        left_flip_mask;
    logic [MASK_W-1:0]        left_phase_mask;
    logic signed [COEF_W-1:0] left_coef_re;
    logic signed [COEF_W-1:0] left_coef_im;
    logic [MASK_W-1:0]        right_flip_mask;
    logic [MASK_W-1:0]        right_phase_mask;
    logic signed [COEF_W-1:0] right_coef_re;
    logic signed [COEF_W-1:0] right_coef_im;
    logic                     prod_valid;
    logic                     prod_stall = 1'b0;
    logic [MASK_W-1:0]        prod_flip_mask;
    logic [MASK_W-1:0]        prod_phase_mask;
    logic signed [COEF_W-1:0] prod_coef_re;
    logic signed [COEF_W-1:0] prod_coef_im;
    logic [1:0]               quarter_turns;
    logic                     coef_saturated;

    // Request on the operand port, with a hand-written product for some directed rows
    operand_pair_t  request;
    logic           request_typed;
    pauli_product_t request_want;

    directed_row_t  rows[$];
    pauli_product_t expected_products[$];
    int             requests_taken = 0;
    int             stuck_cycles = 0;
    int             mismatches = 0;
    int             clipped_count = 0;
    int             turn_count[4] = '{0, 0, 0, 0};
    int             send_gap_pct = 38;
    int             result_stall_pct = 48;

    assign left_flip_mask   = request.left_flip;
    assign left_phase_mask  = request.left_phase;
    assign left_coef_re     = request.left_re;
    assign left_coef_im     = request.left_im;
    assign right_flip_mask  = request.right_flip;
    assign right_phase_mask = request.right_phase;
    assign right_coef_re    = request.right_re;
    assign right_coef_im    = request.right_im;

    pauli_operator_product dut (.*);

    always #6 clk = ~clk;

    // Round a Q.48 value to Q8.24, half away from zero, and clip to 32 bits
    function automatic logic signed [COEF_W-1:0] round_to_q24(
        input  logic signed [EXACT_W-1:0] exact,
        output logic                      clipped
    );
        logic [EXACT_W-1:0] units;
        units = (exact < 0) ? -exact : exact;
        units = (units + HALF_UNIT) >> FRAC_BITS;
        clipped = 1'b0;
        if (exact < 0)
        begin
            if (units > NEG_BOUND)
            begin
                clipped = 1'b1;
                units = NEG_BOUND;
            end
            units = -units;
        end
        else if (units > POS_BOUND)
        begin
            clipped = 1'b1;
            units = POS_BOUND;
        end
        return units[COEF_W-1:0];
    endfunction

    // Predict the product of two Pauli strings
    function automatic pauli_product_t multiply_paulis(input operand_pair_t op);
        logic [MASK_W-1:0]         lf, lp, rf, rp;
        logic [MASK_W-1:0]         xl, yl, zl, xr, yr, zr;
        int unsigned               forward, backward;
        logic signed [EXACT_W-1:0] lre, lim, rre, rim, re, im, swap;
        logic                      clip_re, clip_im;
        pauli_product_t            p;
        lf = op.left_flip & QUBIT_MASK;
        lp = op.left_phase & QUBIT_MASK;
        rf = op.right_flip & QUBIT_MASK;
        rp = op.right_phase & QUBIT_MASK;
        xl = lf & ~lp;
        yl = lf & lp;
        zl = lp & ~lf;
        xr = rf & ~rp;
        yr = rf & rp;
        zr = rp & ~rf;
        forward  = $countones(xl & yr) + $countones(yl & zr) + $countones(zl & xr);
        backward = $countones(xl & zr) + $countones(yl & xr) + $countones(zl & yr);
        p.turns = turn_t'(2'(forward - backward));
        lre = op.left_re;
        lim = op.left_im;
        rre = op.right_re;
        rim = op.right_im;
        re = lre * rre - lim * rim;
        im = lre * rim + lim * rre;
        // Rotate by i^k before rounding
        case (p.turns)
            TURN_1:
            begin
                swap = re;
                re = -im;
                im = swap;
            end
            TURN_2:
            begin
                re = -re;
                im = -im;
            end
            TURN_3:
            begin
                swap = re;
                re = im;
                im = -swap;
            end
            default: ;
        endcase
        p.re = round_to_q24(re, clip_re);
        p.im = round_to_q24(im, clip_im);
        p.clipped = clip_re | clip_im;
        p.flip = lf ^ rf;
        p.phase = lp ^ rp;
        return p;
    endfunction

    function automatic operand_pair_t operands(
        input logic [MASK_W-1:0] lf, lp,
        input logic [COEF_W-1:0] lre, lim,
        input logic [MASK_W-1:0] rf, rp,
        input logic [COEF_W-1:0] rre, rim
    );
        return '{lf, lp, lre, lim, rf, rp, rre, rim};
    endfunction

    function automatic pauli_product_t typed_product(
        input logic [MASK_W-1:0] flip, phase,
        input logic [COEF_W-1:0] re, im,
        input turn_t             turns,
        input logic              clipped
    );
        return '{flip, phase, re, im, turns, clipped};
    endfunction

    // Append one row to the directed table
    function automatic void add_row(input operand_pair_t pair, input logic typed,
                                    input pauli_product_t want);
        rows.insert(rows.size(), '{pair, typed, want});
    endfunction

    function automatic logic [MASK_W-1:0] random_mask();
        case ($urandom_range(3))
            0: return {$urandom, $urandom};
            1: return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
            2: return MASK_W'(1) << $urandom_range(MASK_W - 1);
            default: return {$urandom, $urandom} | {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [COEF_W-1:0] random_coef();
        case ($urandom_range(5))
            0, 1: return $urandom;
            2, 3: return COEF_W'(int'($urandom_range(32'h0800_0000)) - 32'sh0400_0000);
            4:
            begin
                case ($urandom_range(4))
                    0: return MOST_NEG;
                    1: return MOST_POS;
                    2: return LSB;
                    3: return MINUS_LSB;
                    default: return '0;
                endcase
            end
            default: return ($urandom_range(1) != 0) ? ONE : MINUS_ONE;
        endcase
    endfunction

    function automatic operand_pair_t random_pair();
        operand_pair_t op;
        op.left_flip   = random_mask();
        op.left_phase  = random_mask();
        op.left_re     = random_coef();
        op.left_im     = random_coef();
        op.right_flip  = random_mask();
        op.right_phase = random_mask();
        op.right_re    = random_coef();
        op.right_im    = random_coef();
        // Sometimes multiply a string by itself or by its own letters
        if ($urandom_range(9) == 0)
        begin
            op.right_flip  = op.left_flip;
            op.right_phase = op.left_phase;
        end
        return op;
    endfunction

    task automatic compare_field(input string field, input logic [63:0] want,
                                 input logic [63:0] got);
        if (want !== got)
        begin
            mismatches++;
            $display("%0t: %s expected %h, actual %h", $time, field, want, got);
        end
    endtask

    // Offer one request, idling first at the current rate, and hold it until taken
    task automatic send_request(input operand_pair_t pair, input logic typed,
                                input pauli_product_t want);
        int target;
        while ($urandom_range(99) < send_gap_pct)
        begin
            op_valid <= 1'b0;
            @(negedge clk);
        end
        request       <= pair;
        request_typed <= typed;
        request_want  <= want;
        op_valid      <= 1'b1;
        target = requests_taken + 1;
        do
            @(negedge clk);
        while (requests_taken < target);
    endtask

    // Hold off requests until every product has come back
    task automatic drain_products();
        op_valid <= 1'b0;
        while (expected_products.size() != 0)
            @(negedge clk);
    endtask

    // Stall the product port at the current rate
    always @(negedge clk)
    begin
        prod_stall <= ($urandom_range(99) < result_stall_pct);
    end

    // Check products, record taken requests, count cycles with no progress
    always @(posedge clk)
    begin
        pauli_product_t want;
        logic           progress;
        progress = 1'b0;
        if (rst_n && prod_valid && !prod_stall)
        begin
            progress = 1'b1;
            if (expected_products.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected product, actual flip %h phase %h re %h im %h k %0d",
                         $time, prod_flip_mask, prod_phase_mask, prod_coef_re,
                         prod_coef_im, quarter_turns);
            end
            else
            begin
                want = expected_products.pop_front();
                compare_field("prod_flip_mask", want.flip, prod_flip_mask);
                compare_field("prod_phase_mask", want.phase, prod_phase_mask);
                compare_field("prod_coef_re", 64'(unsigned'(want.re)),
                              64'(unsigned'(prod_coef_re)));
                compare_field("prod_coef_im", 64'(unsigned'(want.im)),
                              64'(unsigned'(prod_coef_im)));
                compare_field("quarter_turns", 64'(want.turns), 64'(quarter_turns));
                compare_field("coef_saturated", 64'(want.clipped), 64'(coef_saturated));
            end
            turn_count[quarter_turns]++;
            if (coef_saturated)
                clipped_count++;
        end
        if (rst_n && op_valid && !op_stall)
        begin
            progress = 1'b1;
            expected_products.insert(expected_products.size(),
                                     request_typed ? request_want : multiply_paulis(request));
            requests_taken <= requests_taken + 1;
        end
        stuck_cycles <= progress ? 0 : stuck_cycles + 1;
    end

    // End a run that stops making progress
    initial
    begin
        while (stuck_cycles < STUCK_LIMIT)
            @(posedge clk);
        $display("pauli_operator_product verification failed");
        $finish;
    end

    initial
    begin
        op_valid      = 1'b0;
        request       = '0;
        request_typed = 1'b0;
        request_want  = '0;
        rst_n         = 1'b0;

        // Identity, single-qubit letter pairs, tied letters, extremes, rounding ties
        add_row(operands('0, '0, '0, '0, '0, '0, '0, '0), 1'b1,
                typed_product('0, '0, '0, '0, TURN_0, 1'b0));
        add_row(operands('0, '0, ONE, '0, '0, '0, ONE, '0), 1'b1,
                typed_product('0, '0, ONE, '0, TURN_0, 1'b0));
        add_row(operands(64'd1, '0, ONE, '0, 64'd1, 64'd1, ONE, '0), 1'b1,
                typed_product('0, 64'd1, '0, ONE, TURN_1, 1'b0));
        add_row(operands(64'd1, 64'd1, ONE, '0, 64'd1, '0, ONE, '0), 1'b1,
                typed_product('0, 64'd1, '0, MINUS_ONE, TURN_3, 1'b0));
        add_row(operands('0, 64'd1, ONE, '0, 64'd1, '0, ONE, '0), 1'b0, '0);
        add_row(operands(64'd1, '0, ONE, '0, '0, 64'd1, ONE, '0), 1'b0, '0);
        add_row(operands(64'd1, 64'd1, ONE, '0, '0, 64'd1, ONE, '0), 1'b0, '0);
        add_row(operands('0, 64'd1, ONE, '0, 64'd1, 64'd1, ONE, '0), 1'b0, '0);
        add_row(operands(MASK_ENDS, '0, ONE, '0, MASK_ENDS, MASK_ENDS, ONE, '0), 1'b1,
                typed_product('0, MASK_ENDS, MINUS_ONE, '0, TURN_2, 1'b0));
        add_row(operands(MASK_ALL, MASK_ALL, ONE, '0, MASK_ALL, MASK_ALL, ONE, '0), 1'b1,
                typed_product('0, '0, ONE, '0, TURN_0, 1'b0));
        add_row(operands(MASK_ALL, '0, ONE, '0, '0, MASK_ALL, ONE, '0), 1'b0, '0);
        add_row(operands('0, '0, MOST_NEG, '0, '0, '0, MOST_NEG, '0), 1'b1,
                typed_product('0, '0, MOST_POS, '0, TURN_0, 1'b1));
        add_row(operands('0, '0, MOST_NEG, '0, '0, '0, MOST_POS, '0), 1'b1,
                typed_product('0, '0, MOST_NEG, '0, TURN_0, 1'b1));
        add_row(operands('0, '0, MOST_NEG, '0, '0, '0, ONE, '0), 1'b1,
                typed_product('0, '0, MOST_NEG, '0, TURN_0, 1'b0));
        add_row(operands(64'd3, '0, MOST_NEG, '0, 64'd3, 64'd3, ONE, '0), 1'b1,
                typed_product('0, 64'd3, MOST_POS, '0, TURN_2, 1'b1));
        add_row(operands('0, '0, LSB, '0, '0, '0, HALF, '0), 1'b1,
                typed_product('0, '0, LSB, '0, TURN_0, 1'b0));
        add_row(operands('0, '0, MINUS_LSB, '0, '0, '0, HALF, '0), 1'b1,
                typed_product('0, '0, MINUS_LSB, '0, TURN_0, 1'b0));
        add_row(operands('0, '0, LSB, '0, '0, '0, HALF - LSB, '0), 1'b0, '0);
        add_row(operands('0, '0, '0, ONE, '0, '0, '0, ONE), 1'b1,
                typed_product('0, '0, MINUS_ONE, '0, TURN_0, 1'b0));
        add_row(operands(MASK_ALL, MASK_ALL, MOST_NEG, MOST_NEG, MASK_ALL, '0,
                         MOST_NEG, MOST_POS), 1'b0, '0);
        add_row(operands(MASK_ALL, MASK_ALL, MOST_POS, MOST_POS, MASK_ALL, MASK_ALL,
                         MOST_POS, MOST_POS), 1'b0, '0);
        add_row(operands(MASK_TOP, '0, MOST_NEG, MOST_NEG, MASK_TOP, MASK_TOP,
                         MOST_NEG, ONE), 1'b0, '0);

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed rows, sender idling 38 and receiver 48 in a hundred
        foreach (rows[i])
            send_request(rows[i].pair, rows[i].typed, rows[i].want);
        repeat (PHASE1_ITEMS) send_request(random_pair(), 1'b0, '0);
        drain_products();

        // Swap the idling of the two sides
        send_gap_pct = 48;
        result_stall_pct = 38;
        repeat (PHASE2_ITEMS) send_request(random_pair(), 1'b0, '0);
        drain_products();

        // Full rate on both sides
        send_gap_pct = 0;
        result_stall_pct = 0;
        repeat (PHASE3_ITEMS) send_request(random_pair(), 1'b0, '0);
        drain_products();
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Ran %0d Pauli string products (%0d clipped, k = 0/1/2/3 seen %0d/%0d/%0d/%0d)",
                 requests_taken, clipped_count, turn_count[0], turn_count[1],
                 turn_count[2], turn_count[3]);
        $display("under swapped sender and receiver idling, then a full-rate burst; %0d mismatches",
                 mismatches);
        if (mismatches == 0)
            $display("pauli_operator_product verification clean");
        else
            $display("pauli_operator_product verification failed");
        $finish;
    end

endmodule
